/* sv/idiv_pkg.sv */
// Shared types and constants for the pipelined integer divider.
package idiv_pkg;

    // Width of the payload fields on the channels.
    localparam int unsigned FIELD_W = 64;
    localparam int unsigned CMD_W   = 2;

    // Operation codes carried in the cmd field.
    typedef enum logic [CMD_W-1:0] {
        CMD_UQUO = 2'd0,
        CMD_UREM = 2'd1,
        CMD_SQUO = 2'd2,
        CMD_SREM = 2'd3
    } idiv_cmd_t;

    // Control that travels with an item down the divide stages.
    typedef struct packed {
        logic sel_rem;   // deliver the remainder instead of the quotient
        logic neg;       // negate the selected magnitude at the end
        logic div_zero;  // divisor was zero, result is forced to zero
    } idiv_ctrl_t;

    // One finished item as held in the output queue.
    typedef struct packed {
        logic [FIELD_W-1:0] result;
        logic               divisor_zero;
    } idiv_rsp_t;

    // Occupancy of the two-entry output queue.
    typedef struct packed {
        logic head_valid;
        logic tail_valid;
    } idiv_qstat_t;

endpackage

/* sv/idiv_req_if.sv */
// Request channel: operation code and the two operands.
interface idiv_req_if;
    import idiv_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [FIELD_W-1:0] dividend;
    logic [FIELD_W-1:0] divisor;

    modport source (output valid, output cmd, output dividend, output divisor, input ready);
    modport sink   (input valid, input cmd, input dividend, input divisor, output ready);
endinterface

/* sv/idiv_rsp_if.sv */
// Response channel: quotient or remainder and the zero-divisor flag.
interface idiv_rsp_if;
    import idiv_pkg::*;

    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] result;
    logic               divisor_zero;

    modport source (output valid, output result, output divisor_zero, input ready);
    modport sink   (input valid, input result, input divisor_zero, output ready);
endinterface

/* sv/idiv_prep.sv */
// Input stage: decodes the operation and takes operand magnitudes.
module idiv_prep #(
    parameter int unsigned WIDTH = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    idiv_req_if.sink             req,
    output logic                 out_valid,
    output idiv_pkg::idiv_ctrl_t out_ctrl,
    output logic [WIDTH-1:0]     out_aq,
    output logic [WIDTH-1:0]     out_b
);
    import idiv_pkg::*;

    logic             valid_reg, valid_next;
    idiv_ctrl_t       ctrl_reg, ctrl_next;
    logic [WIDTH-1:0] aq_reg, aq_next;
    logic [WIDTH-1:0] b_reg, b_next;
    logic [WIDTH-1:0] a_raw, b_raw;
    logic             is_signed, a_neg, b_neg;
    idiv_cmd_t        cmd;

    // The pipeline takes a new item whenever it advances.
    assign req.ready = en;

    // Decode the operation and form the operand magnitudes.
    always_comb
    begin
        cmd       = idiv_cmd_t'(req.cmd);
        a_raw     = req.dividend[WIDTH-1:0];
        b_raw     = req.divisor[WIDTH-1:0];
        is_signed = 1'b0;
        ctrl_next = '0;
        unique case (cmd)
            CMD_UQUO:
            begin
                is_signed         = 1'b0;
                ctrl_next.sel_rem = 1'b0;
            end
            CMD_UREM:
            begin
                is_signed         = 1'b0;
                ctrl_next.sel_rem = 1'b1;
            end
            CMD_SQUO:
            begin
                is_signed         = 1'b1;
                ctrl_next.sel_rem = 1'b0;
            end
            CMD_SREM:
            begin
                is_signed         = 1'b1;
                ctrl_next.sel_rem = 1'b1;
            end
        endcase
        a_neg              = is_signed & a_raw[WIDTH-1];
        b_neg              = is_signed & b_raw[WIDTH-1];
        // A quotient is negative when the signs differ, a remainder follows the dividend.
        ctrl_next.neg      = ctrl_next.sel_rem ? a_neg : (a_neg ^ b_neg);
        ctrl_next.div_zero = (b_raw == '0);
        aq_next            = a_neg ? ('0 - a_raw) : a_raw;
        b_next             = b_neg ? ('0 - b_raw) : b_raw;
        valid_next         = en ? req.valid : valid_reg;
    end

    // Valid bit of the stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload of the stage.
    always_ff @(posedge clk)
    begin
        if (en && req.valid)
        begin
            ctrl_reg <= ctrl_next;
            aq_reg   <= aq_next;
            b_reg    <= b_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctrl  = ctrl_reg;
    assign out_aq    = aq_reg;
    assign out_b     = b_reg;

endmodule

/* sv/idiv_step.sv */
// One restoring divide step: shift in a dividend bit, trial subtract, keep or restore.
module idiv_step #(
    parameter int unsigned WIDTH = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  idiv_pkg::idiv_ctrl_t in_ctrl,
    input  logic [WIDTH-1:0]     in_r,
    input  logic [WIDTH-1:0]     in_aq,
    input  logic [WIDTH-1:0]     in_b,
    output logic                 out_valid,
    output idiv_pkg::idiv_ctrl_t out_ctrl,
    output logic [WIDTH-1:0]     out_r,
    output logic [WIDTH-1:0]     out_aq,
    output logic [WIDTH-1:0]     out_b
);
    import idiv_pkg::*;

    logic             valid_reg, valid_next;
    idiv_ctrl_t       ctrl_reg;
    logic [WIDTH-1:0] r_reg, r_next;
    logic [WIDTH-1:0] aq_reg, aq_next;
    logic [WIDTH-1:0] b_reg;
    logic [WIDTH:0]   rem_shift;
    logic [WIDTH+1:0] diff;
    logic             take;

    // The partial remainder keeps its carry bit, so the compare is one bit wider.
    always_comb
    begin
        rem_shift  = {in_r, in_aq[WIDTH-1]};
        diff       = {1'b0, rem_shift} - {2'b00, in_b};
        take       = ~diff[WIDTH+1];
        r_next     = take ? diff[WIDTH-1:0] : rem_shift[WIDTH-1:0];
        // Dividend bits leave at the top while quotient bits enter at the bottom.
        aq_next    = {in_aq[WIDTH-2:0], take};
        valid_next = en ? in_valid : valid_reg;
    end

    // Valid bit of the stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload of the stage.
    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            ctrl_reg <= in_ctrl;
            r_reg    <= r_next;
            aq_reg   <= aq_next;
            b_reg    <= in_b;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctrl  = ctrl_reg;
    assign out_r     = r_reg;
    assign out_aq    = aq_reg;
    assign out_b     = b_reg;

endmodule

/* sv/idiv_post.sv */
// Output stage: sign fix-up, zero-divisor override and a two-entry result queue.
module idiv_post #(
    parameter int unsigned WIDTH = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  idiv_pkg::idiv_ctrl_t  in_ctrl,
    input  logic [WIDTH-1:0]      in_r,
    input  logic [WIDTH-1:0]      in_q,
    idiv_rsp_if.source            rsp,
    output idiv_pkg::idiv_qstat_t stat
);
    import idiv_pkg::*;

    logic             head_valid_reg, head_valid_next;
    logic             tail_valid_reg, tail_valid_next;
    idiv_rsp_t        head_reg, head_next;
    idiv_rsp_t        tail_reg, tail_next;
    idiv_rsp_t        push_item;
    logic [WIDTH-1:0] res_sel, res_fix;
    logic             push, pop;

    // Pick quotient or remainder and restore its sign.
    always_comb
    begin
        res_sel                = in_ctrl.sel_rem ? in_r : in_q;
        res_fix                = in_ctrl.neg ? ('0 - res_sel) : res_sel;
        push_item.result       = in_ctrl.div_zero ? '0 : FIELD_W'(res_fix);
        push_item.divisor_zero = in_ctrl.div_zero;
    end

    // Queue control: the head feeds the channel, the tail catches an item during a stall.
    always_comb
    begin
        push            = en & in_valid;
        pop             = head_valid_reg & rsp.ready;
        head_valid_next = head_valid_reg;
        tail_valid_next = tail_valid_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        if (pop || !head_valid_reg)
        begin
            if (tail_valid_reg)
            begin
                head_next       = tail_reg;
                head_valid_next = 1'b1;
                tail_next       = push_item;
                tail_valid_next = push;
            end
            else
            begin
                head_next       = push_item;
                head_valid_next = push;
                tail_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            tail_next       = push_item;
            tail_valid_next = 1'b1;
        end
    end

    // Queue occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            tail_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            tail_valid_reg <= tail_valid_next;
        end
    end

    // Queue entries.
    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    assign rsp.valid        = head_valid_reg;
    assign rsp.result       = head_reg.result;
    assign rsp.divisor_zero = head_reg.divisor_zero;

    assign stat.head_valid = head_valid_reg;
    assign stat.tail_valid = tail_valid_reg;

endmodule

/* sv/integer_divider_64_top.sv */
// Top level of the pipelined 64-bit integer divider.
//
// Usage: an item on req carries cmd (unsigned quotient, unsigned remainder,
// signed quotient, signed remainder), dividend and divisor; only the low
// WIDTH bits of the operands are used. Each item gives one item on rsp with
// the quotient or remainder, zero-extended to 64 bits, and divisor_zero.
// A zero divisor gives a result of zero with divisor_zero set. Signed
// division truncates toward zero; the most negative value over minus one
// wraps to itself.
//
// Pipeline: the operand stage captures the item at the accepting edge, then
// one restoring step stage per quotient bit and the sign fix-up into the
// output queue follow. Throughput: one item per cycle while the output
// queue has a free entry.
//
// Reset clears every valid bit; no item is in flight afterward.
// When rsp stalls, a two-entry output queue keeps taking finished items;
// once both entries are full, req.ready drops and the whole pipeline holds
// until the head item is taken.
module integer_divider_64_top #(
    parameter int unsigned WIDTH = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    idiv_req_if.sink   req,
    idiv_rsp_if.source rsp
);
    import idiv_pkg::*;

    logic             pipe_en;
    idiv_qstat_t      q_stat;
    logic             st_valid [WIDTH+1];
    idiv_ctrl_t       st_ctrl  [WIDTH+1];
    logic [WIDTH-1:0] st_r     [WIDTH+1];
    logic [WIDTH-1:0] st_aq    [WIDTH+1];
    logic [WIDTH-1:0] st_b     [WIDTH+1];

    // The pipeline advances as long as the output queue has a free entry.
    assign pipe_en = ~q_stat.tail_valid;

    // Operand stage.
    idiv_prep #(
        .WIDTH (WIDTH)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .req       (req),
        .out_valid (st_valid[0]),
        .out_ctrl  (st_ctrl[0]),
        .out_aq    (st_aq[0]),
        .out_b     (st_b[0])
    );

    // The partial remainder starts at zero.
    assign st_r[0] = '0;

    // One restoring step per quotient bit, most significant bit first.
    for (genvar k = 0; k < WIDTH; k++)
    begin : g_step
        idiv_step #(
            .WIDTH (WIDTH)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (pipe_en),
            .in_valid  (st_valid[k]),
            .in_ctrl   (st_ctrl[k]),
            .in_r      (st_r[k]),
            .in_aq     (st_aq[k]),
            .in_b      (st_b[k]),
            .out_valid (st_valid[k+1]),
            .out_ctrl  (st_ctrl[k+1]),
            .out_r     (st_r[k+1]),
            .out_aq    (st_aq[k+1]),
            .out_b     (st_b[k+1])
        );
    end

    // Sign fix-up and output queue.
    idiv_post #(
        .WIDTH (WIDTH)
    ) u_post (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pipe_en),
        .in_valid (st_valid[WIDTH]),
        .in_ctrl  (st_ctrl[WIDTH]),
        .in_r     (st_r[WIDTH]),
        .in_q     (st_aq[WIDTH]),
        .rsp      (rsp),
        .stat     (q_stat)
    );

`ifndef SYNTHESIS
    // A full output queue must hold off new items.
    a_full_blocks_req: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.tail_valid |-> !req.ready)
        else $error("request accepted while the output queue is full");

    // The tail entry is only filled behind a waiting head entry.
    a_tail_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.tail_valid |-> q_stat.head_valid)
        else $error("output queue tail valid without head");

    // A zero divisor always delivers a zero result.
    a_zero_div_result: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.divisor_zero) |-> (rsp.result == '0))
        else $error("nonzero result for a zero divisor");

    // A stalled head item is not replaced before it is taken.
    a_head_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (q_stat.head_valid && !rsp.ready) |=> (q_stat.head_valid && $stable(rsp.result)))
        else $error("stalled result changed before it was taken");
`endif

endmodule

/* sim/integer_divider_64_top_tb.sv */
// Self-checking testbench for the pipelined 64-bit integer divider.
`timescale 1ns / 100ps

module integer_divider_64_top_tb;
    import idiv_pkg::*;

    localparam int unsigned LONG_HOLD   = 400;
    localparam int unsigned QUIET_LIMIT = 4000;
    localparam int unsigned MAX_REPORTS = 10;
    localparam int unsigned SETTLE      = 80;

    localparam logic [FIELD_W-1:0] ALL_ONES = {FIELD_W{1'b1}};
    localparam logic [FIELD_W-1:0] MOST_NEG = {1'b1, {(FIELD_W-1){1'b0}}};
    localparam logic [FIELD_W-1:0] MOST_POS = {1'b0, {(FIELD_W-1){1'b1}}};

    // Expected division results in order, plus what the run has seen.
    class div_result_book;
        idiv_rsp_t   pending[$];
        int unsigned failures;
        int unsigned checked;
        int unsigned zero_divs;
        int unsigned wraps;
        int unsigned per_op[4];

        // Quotient or remainder of one item, worked out on magnitudes.
        function idiv_rsp_t expected_division(idiv_cmd_t op, logic [FIELD_W-1:0] a,
                                              logic [FIELD_W-1:0] b);
            idiv_rsp_t          r;
            logic [FIELD_W-1:0] a_mag;
            logic [FIELD_W-1:0] b_mag;
            logic [FIELD_W-1:0] quo;
            logic [FIELD_W-1:0] rem;
            logic               is_signed;
            logic               a_neg;
            logic               b_neg;
            r.result       = '0;
            r.divisor_zero = 1'b0;
            if (b == '0)
            begin
                r.divisor_zero = 1'b1;
                return r;
            end
            is_signed = (op == CMD_SQUO) || (op == CMD_SREM);
            a_neg     = is_signed && a[FIELD_W-1];
            b_neg     = is_signed && b[FIELD_W-1];
            a_mag     = a_neg ? -a : a;
            b_mag     = b_neg ? -b : b;
            quo       = a_mag / b_mag;
            rem       = a_mag % b_mag;
            case (op)
                CMD_UQUO: r.result = quo;
                CMD_UREM: r.result = rem;
                CMD_SQUO: r.result = (a_neg != b_neg) ? -quo : quo;
                default:  r.result = a_neg ? -rem : rem;
            endcase
            return r;
        endfunction

        // An item was taken by the block: queue what it must produce.
        function void note_request(idiv_cmd_t op, logic [FIELD_W-1:0] a,
                                   logic [FIELD_W-1:0] b);
            per_op[int'(op)]++;
            if (b == '0)
                zero_divs++;
            if ((op == CMD_SQUO || op == CMD_SREM) && a == MOST_NEG && b == ALL_ONES)
                wraps++;
            pending.push_back(expected_division(op, a, b));
        endfunction

        // A result left the block: compare it with the oldest expectation.
        function void check_response(logic [FIELD_W-1:0] result, logic zero_flag);
            idiv_rsp_t want;
            if (pending.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("ERROR: unexpected result %h divisor_zero=%b", result, zero_flag);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (want.result !== result || want.divisor_zero !== zero_flag)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("ERROR: result %0d: expected %h zero=%b, got %h zero=%b",
                             checked, want.result, want.divisor_zero, result, zero_flag);
            end
        endfunction

        // Results still owed at the end count as failures.
        function int unsigned close_out();
            if (pending.size() != 0)
            begin
                $display("ERROR: %0d expected results never arrived", pending.size());
                failures += pending.size();
            end
            return failures;
        endfunction
    endclass

    logic           clk = 1'b0;
    logic           rst_n;
    idiv_req_if     req();
    idiv_rsp_if     rsp();
    div_result_book book;

    // Pacing controls shared by the stimulus and the response side.
    bit tx_steady    = 1'b0;
    bit rx_steady    = 1'b0;
    bit hold_request = 1'b0;

    idiv_cmd_t op_list[4] = '{CMD_UQUO, CMD_UREM, CMD_SQUO, CMD_SREM};

    integer_divider_64_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // 2 ns clock.
    always
    begin
        #1;
        clk = 1'b1;
        #1;
        clk = 1'b0;
    end

    // Record accepted items, check accepted results, and watch for a hang.
    always @(posedge clk)
    begin : monitor
        static int unsigned quiet_cycles = 0;
        if (rst_n === 1'b1)
        begin
            if (req.valid && req.ready)
                book.note_request(idiv_cmd_t'(req.cmd), req.dividend, req.divisor);
            if (rsp.valid && rsp.ready)
                book.check_response(rsp.result, rsp.divisor_zero);
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles == QUIET_LIMIT)
            begin
                $display("Watchdog: no handshake for %0d cycles", QUIET_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // Offer one item, after a random gap unless tx_steady is set, and hold it until it is taken.
    task automatic offer_division(input idiv_cmd_t op, input logic [FIELD_W-1:0] a,
                                  input logic [FIELD_W-1:0] b);
        int unsigned gap;
        gap = tx_steady ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid    <= 1'b1;
        req.cmd      <= op;
        req.dividend <= a;
        req.divisor  <= b;
        do
            @(posedge clk);
        while (!(req.valid && req.ready));
    endtask

    // Stop offering and wait until every outstanding result is back.
    task automatic drain_results();
        req.valid <= 1'b0;
        @(posedge clk);
        while (book.pending.size() != 0)
            @(posedge clk);
    endtask

    // Operand with a spread of magnitudes, signs and edge values.
    function automatic logic [FIELD_W-1:0] random_operand();
        logic [FIELD_W-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: v = v >> $urandom_range(0, FIELD_W - 1);
            1: v = {{(FIELD_W-8){1'b0}}, v[7:0]};
            2: v = -{{(FIELD_W-8){1'b0}}, v[7:0]};
            3: v = MOST_NEG;
            4: v = v[0] ? MOST_POS : MOST_NEG + 1'b1;
            5: v = ALL_ONES;
            6: v = v >> $urandom_range(FIELD_W / 2, FIELD_W - 1);
            7: v = -(v >> $urandom_range(FIELD_W / 2, FIELD_W - 1));
            default: ;
        endcase
        return v;
    endfunction

    // Random item: mostly mixed operands, some zero divisors and wrap cases.
    task automatic offer_random_division();
        idiv_cmd_t          op;
        logic [FIELD_W-1:0] a;
        logic [FIELD_W-1:0] b;
        op = op_list[$urandom_range(0, 3)];
        a  = random_operand();
        b  = random_operand();
        if ($urandom_range(0, 29) == 0)
            b = '0;
        else if ($urandom_range(0, 39) == 0)
        begin
            a = MOST_NEG;
            b = ALL_ONES;
        end
        offer_division(op, a, b);
    endtask

    // Response side: random stalls, steady stretches, and one long hold-off.
    initial
    begin : response_side
        int unsigned stall;
        rsp.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                stall        = LONG_HOLD;
                hold_request = 1'b0;
            end
            else if (rx_steady)
                stall = 0;
            else
                stall = $urandom_range(0, 15);
            if (stall != 0)
            begin
                rsp.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(rsp.valid && rsp.ready));
        end
    end

    // Reset, directed cases, random phases, final check.
    initial
    begin : stimulus
        int unsigned phase;
        int unsigned k;
        int unsigned failures;
        book         = new();
        rst_n        <= 1'b0;
        req.valid    <= 1'b0;
        req.cmd      <= CMD_UQUO;
        req.dividend <= '0;
        req.divisor  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sign combinations of a plain division.
        offer_division(CMD_UQUO, 64'd100, 64'd7);
        offer_division(CMD_UREM, 64'd100, 64'd7);
        offer_division(CMD_SQUO, -64'd100, 64'd7);
        offer_division(CMD_SREM, -64'd100, 64'd7);
        offer_division(CMD_SQUO, 64'd100, -64'd7);
        offer_division(CMD_SREM, 64'd100, -64'd7);
        offer_division(CMD_SQUO, -64'd100, -64'd7);
        offer_division(CMD_SREM, -64'd100, -64'd7);
        // Field extremes.
        offer_division(CMD_UQUO, ALL_ONES, 64'd1);
        offer_division(CMD_UREM, ALL_ONES, ALL_ONES);
        offer_division(CMD_UQUO, MOST_NEG, ALL_ONES);
        offer_division(CMD_UREM, ALL_ONES, MOST_NEG);
        offer_division(CMD_UQUO, 64'd0, ALL_ONES);
        offer_division(CMD_UREM, 64'd3, 64'd5);
        offer_division(CMD_SQUO, MOST_NEG, 64'd1);
        offer_division(CMD_SQUO, MOST_POS, MOST_NEG);
        offer_division(CMD_SREM, MOST_POS, MOST_NEG);
        offer_division(CMD_SREM, ALL_ONES, MOST_NEG);
        offer_division(CMD_SQUO, MOST_NEG, MOST_NEG);
        // Most negative over minus one wraps.
        offer_division(CMD_SQUO, MOST_NEG, ALL_ONES);
        offer_division(CMD_SREM, MOST_NEG, ALL_ONES);
        // Zero divisor under every operation.
        offer_division(CMD_UQUO, 64'd5, 64'd0);
        offer_division(CMD_UREM, 64'd5, 64'd0);
        offer_division(CMD_SQUO, MOST_NEG, 64'd0);
        offer_division(CMD_SREM, ALL_ONES, 64'd0);
        drain_results();

        // Random phases with different pacing on each side.
        for (phase = 0; phase < 6; phase++)
        begin
            tx_steady = (phase == 1) || (phase == 3) || (phase == 4);
            rx_steady = (phase == 1) || (phase == 5);
            // Output stalls for a long stretch while input keeps coming.
            if (phase == 3)
                hold_request = 1'b1;
            for (k = 0; k < 200; k++)
                offer_random_division();
            if (phase == 1 || phase == 3)
                drain_results();
        end
        drain_results();
        repeat (SETTLE) @(posedge clk);

        failures = book.close_out();
        $display("Covered %0d items (uquo %0d, urem %0d, squo %0d, srem %0d), %0d checked,",
                 book.per_op[0] + book.per_op[1] + book.per_op[2] + book.per_op[3],
                 book.per_op[0], book.per_op[1], book.per_op[2], book.per_op[3],
                 book.checked);
        $display("  %0d zero divisors, %0d most-negative over minus one, one long output stall.",
                 book.zero_divs, book.wraps);
        if (failures == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
